@@ design/assert_macros.svh @@
// Assertion macros used by the parser design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define APC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define APC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define APC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define APC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/apc_pkg.sv @@
// Types and character constants of the graphics command parser.
package apc_pkg;

	localparam int KEY_INDEX_W = 5;

	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_US    = 8'h5f;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_M     = 8'h6d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [15:0] COUNT_MAX = 16'hffff;

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_ESC,
		PH_US,
		PH_KEYS,
		PH_PAYLOAD,
		PH_TERM,
		PH_DRAIN
	} phase_t;

	typedef enum logic [1:0] {
		SEG_KEY,
		SEG_AFTER_KEY,
		SEG_VALUE,
		SEG_SKIP
	} seg_t;

	typedef enum logic [1:0] {
		NUM_LEAD,
		NUM_SIGN,
		NUM_DIGITS,
		NUM_DONE
	} num_step_t;

	typedef enum logic [2:0] {
		KIND_KEY     = 3'd0,
		KIND_VALUE   = 3'd1,
		KIND_PAYLOAD = 3'd2,
		KIND_OK      = 3'd3,
		KIND_ERR     = 3'd4
	} kind_t;

	typedef struct packed {
		num_step_t   step;
		logic        negative;
		logic        has_digit;
		logic [31:0] value;
	} m_num_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_buffer;
	} apc_in_t;

	typedef struct packed {
		logic [2:0]             kind;
		logic [7:0]             token_byte;
		logic [KEY_INDEX_W-1:0] key_index;
		logic [7:0]             action_code;
		logic                   more_chunks;
		logic [15:0]            parsed_total;
		logic [15:0]            error_total;
	} apc_out_t;

endpackage

@@ design/apc_stream_if.sv @@
// Valid/ready stream interface that carries one payload per transaction.
interface apc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ design/apc_graphics_command_parser_core.sv @@
// Top level of the graphics command parser: input register, parser step and result register.
//
//  channel  | role   | payload
//  ---------+--------+---------------------------------------------------------
//  bytes    | sink   | in_byte, end_of_buffer
//  tokens   | source | kind, token_byte, key_index, action_code, more_chunks,
//           |        | parsed_total, error_total
//
// One byte per cycle unless tokens stalls; a byte's result is offered from the
// result register. The parse state is a handful of small registers updated once
// per byte. Reset clears the parse state and both counters; no clearing pass is
// needed. A stalled tokens channel holds the result register and, once the input
// register is full, back-pressures bytes through the same cycle.
module apc_graphics_command_parser_core #(
	parameter int MAX_KEY_ENTRIES = 32,
	parameter int PAYLOAD_BYTES   = 4096,
	parameter int VALUE_BYTES     = 16
) (
	input logic         clk,
	input logic         arst_n,
	apc_stream_if.sink   bytes,
	apc_stream_if.source tokens
);
	import apc_pkg::*;

	apc_in_t  item_s1;
	logic     item_vld_s1;
	apc_out_t res_s2;
	logic     res_vld_s2;
	apc_out_t res;
	logic     res_vld;
	logic     fire;
	logic     take;

	assign fire = item_vld_s1 && (!res_vld_s2 || tokens.ready);
	assign take = bytes.valid && bytes.ready;
	assign bytes.ready = !item_vld_s1 || fire;

	apc_parser #(
		.MAX_KEY_ENTRIES(MAX_KEY_ENTRIES),
		.PAYLOAD_BYTES(PAYLOAD_BYTES),
		.VALUE_BYTES(VALUE_BYTES)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.item(item_s1),
		.res_vld(res_vld),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
			res_vld_s2 <= 1'b0;
		end else begin
			if (take) item_vld_s1 <= 1'b1;
			else if (fire) item_vld_s1 <= 1'b0;
			if (fire) res_vld_s2 <= res_vld;
			else if (tokens.ready) res_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) item_s1 <= bytes.payload;
		if (fire) res_s2 <= res;
	end

	assign tokens.valid = res_vld_s2;
	assign tokens.payload = res_s2;

endmodule

@@ design/apc_parser.sv @@
// Parser state and the combinational step that turns one byte into at most one result.
`include "assert_macros.svh"
module apc_parser #(
	parameter int MAX_KEY_ENTRIES = 32,
	parameter int PAYLOAD_BYTES   = 4096,
	parameter int VALUE_BYTES     = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  apc_pkg::apc_in_t  item,
	output logic              res_vld,
	output apc_pkg::apc_out_t res
);
	import apc_pkg::*;

	localparam int KW = $clog2(MAX_KEY_ENTRIES + 1);
	localparam int VW = $clog2(VALUE_BYTES);
	localparam int PW = $clog2(PAYLOAD_BYTES);
	localparam logic [KW-1:0] KEYS_MAX  = KW'(MAX_KEY_ENTRIES);
	localparam logic [KW-1:0] KEY_ONE   = KW'(1);
	localparam logic [VW-1:0] VAL_LIMIT = VW'(VALUE_BYTES - 1);
	localparam logic [VW-1:0] VAL_ONE   = VW'(1);
	localparam logic [PW-1:0] PAY_LIMIT = PW'(PAYLOAD_BYTES - 1);
	localparam logic [PW-1:0] PAY_ONE   = PW'(1);

	phase_t      phase_q, phase_m, phase_n;
	logic [KW-1:0] keys_q, keys_m, keys_n;
	seg_t        seg_q, seg_m, seg_n;
	logic [VW-1:0] vlen_q, vlen_m, vlen_n;
	logic [PW-1:0] plen_q, plen_m, plen_n;
	logic [7:0]  act_q, act_m, act_n;
	logic        act_found_q, act_found_m, act_found_n;
	logic        m_seen_q, m_seen_m, m_seen_n;
	logic        m_cur_q, m_cur_m, m_cur_n;
	logic [7:0]  cur_key_q, cur_key_m, cur_key_n;
	m_num_t      num_q, num_m, num_n;
	logic [15:0] parsed_q, parsed_n;
	logic [15:0] errors_q, errors_n;

	logic        tok;
	kind_t       tok_kind;
	logic        early;
	logic        ok;
	logic        verdict;
	logic [7:0]  b;
	logic        last;

	function automatic m_num_t feed_number(m_num_t cur, logic [7:0] ch);
		m_num_t r;
		logic   go;
		logic   digit;
		r = cur;
		go = 1'b0;
		digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
		case (cur.step)
			NUM_LEAD: begin
				if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
					go = 1'b0;
				end else if (ch == CH_PLUS) begin
					r.step = NUM_SIGN;
				end else if (ch == CH_MINUS) begin
					r.negative = 1'b1;
					r.step = NUM_SIGN;
				end else begin
					go = 1'b1;
				end
			end
			NUM_SIGN, NUM_DIGITS: go = 1'b1;
			default: go = 1'b0;
		endcase
		if (go) begin
			if (digit) begin
				r.value = (cur.value << 3) + (cur.value << 1) + 32'(ch - CH_ZERO);
				r.has_digit = 1'b1;
				r.step = NUM_DIGITS;
			end else begin
				r.step = NUM_DONE;
			end
		end
		return r;
	endfunction

	assign b    = item.in_byte;
	assign last = item.end_of_buffer;

	// Effect of the byte on the parse state, before the verdict and end-of-buffer rules.
	always_comb begin
		phase_m = phase_q;
		keys_m = keys_q;
		seg_m = seg_q;
		vlen_m = vlen_q;
		plen_m = plen_q;
		act_m = act_q;
		act_found_m = act_found_q;
		m_seen_m = m_seen_q;
		m_cur_m = m_cur_q;
		cur_key_m = cur_key_q;
		num_m = num_q;
		tok = 1'b0;
		tok_kind = KIND_KEY;
		early = 1'b0;
		ok = 1'b0;
		unique case (phase_q)
			PH_SEARCH: begin
				if (b == CH_ESC) phase_m = PH_ESC;
			end
			PH_ESC: begin
				if (b == CH_US) phase_m = PH_US;
				else if (b != CH_ESC) phase_m = PH_SEARCH;
			end
			PH_US: begin
				if (b == CH_G) begin
					phase_m = PH_KEYS;
					seg_m = SEG_KEY;
				end else if (b == CH_ESC) begin
					phase_m = PH_ESC;
				end else begin
					phase_m = PH_SEARCH;
				end
			end
			PH_KEYS: begin
				if (b == CH_SEMI) begin
					phase_m = PH_PAYLOAD;
				end else if (b == CH_ESC) begin
					phase_m = PH_TERM;
				end else if (b == CH_COMMA) begin
					if (seg_q == SEG_KEY) early = 1'b1;
					else seg_m = SEG_KEY;
				end else if (seg_q == SEG_KEY) begin
					if (keys_q >= KEYS_MAX) begin
						early = 1'b1;
					end else begin
						tok = 1'b1;
						tok_kind = KIND_KEY;
						keys_m = keys_q + KEY_ONE;
						cur_key_m = b;
						seg_m = SEG_AFTER_KEY;
						vlen_m = '0;
						m_cur_m = (b == CH_M) && !m_seen_q;
						if ((b == CH_M) && !m_seen_q) m_seen_m = 1'b1;
					end
				end else if (seg_q == SEG_AFTER_KEY) begin
					seg_m = (b == CH_EQ) ? SEG_VALUE : SEG_SKIP;
				end else if (seg_q == SEG_VALUE) begin
					if (vlen_q < VAL_LIMIT) begin
						tok = 1'b1;
						tok_kind = KIND_VALUE;
						if (vlen_q == '0 && cur_key_q == CH_A && !act_found_q && b != 8'h00) begin
							act_m = b;
							act_found_m = 1'b1;
						end
						if (m_cur_q) num_m = feed_number(num_q, b);
						vlen_m = vlen_q + VAL_ONE;
					end
				end
			end
			PH_PAYLOAD: begin
				if (b == CH_ESC) begin
					phase_m = PH_TERM;
				end else if (plen_q < PAY_LIMIT) begin
					tok = 1'b1;
					tok_kind = KIND_PAYLOAD;
					plen_m = plen_q + PAY_ONE;
				end else begin
					early = 1'b1;
				end
			end
			PH_TERM: begin
				early = 1'b1;
				ok = (b == CH_BSL);
			end
			default: ;
		endcase
	end

	assign verdict = early || (last && phase_q != PH_DRAIN);

	// Verdict bookkeeping and the clear at the last byte of a buffer.
	always_comb begin
		phase_n = verdict ? PH_DRAIN : phase_m;
		keys_n = keys_m;
		seg_n = seg_m;
		vlen_n = vlen_m;
		plen_n = plen_m;
		act_n = act_m;
		act_found_n = act_found_m;
		m_seen_n = m_seen_m;
		m_cur_n = m_cur_m;
		cur_key_n = cur_key_m;
		num_n = num_m;
		parsed_n = parsed_q;
		errors_n = errors_q;
		if (verdict) begin
			if (ok) begin
				if (parsed_q != COUNT_MAX) parsed_n = parsed_q + 16'd1;
			end else begin
				if (errors_q != COUNT_MAX) errors_n = errors_q + 16'd1;
			end
		end
		if (last) begin
			phase_n = PH_SEARCH;
			keys_n = '0;
			seg_n = SEG_KEY;
			vlen_n = '0;
			plen_n = '0;
			act_n = CH_T;
			act_found_n = 1'b0;
			m_seen_n = 1'b0;
			m_cur_n = 1'b0;
			cur_key_n = 8'h00;
			num_n = '0;
		end
	end

	always_comb begin
		res_vld = verdict || tok;
		res = '0;
		res.parsed_total = parsed_n;
		res.error_total = errors_n;
		if (verdict) begin
			res.kind = ok ? KIND_OK : KIND_ERR;
			res.action_code = act_m;
			res.more_chunks = num_m.has_digit &&
				(num_m.negative ? (num_m.value == 32'hffff_ffff) : (num_m.value == 32'd1));
		end else begin
			res.kind = tok_kind;
			res.token_byte = b;
			if (tok_kind == KIND_KEY) res.key_index = KEY_INDEX_W'(keys_q);
			else if (tok_kind == KIND_VALUE) res.key_index = KEY_INDEX_W'(keys_q - KEY_ONE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			keys_q <= '0;
			seg_q <= SEG_KEY;
			vlen_q <= '0;
			plen_q <= '0;
			act_q <= CH_T;
			act_found_q <= 1'b0;
			m_seen_q <= 1'b0;
			m_cur_q <= 1'b0;
			cur_key_q <= 8'h00;
			num_q <= '0;
			parsed_q <= '0;
			errors_q <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			keys_q <= keys_n;
			seg_q <= seg_n;
			vlen_q <= vlen_n;
			plen_q <= plen_n;
			act_q <= act_n;
			act_found_q <= act_found_n;
			m_seen_q <= m_seen_n;
			m_cur_q <= m_cur_n;
			cur_key_q <= cur_key_n;
			num_q <= num_n;
			parsed_q <= parsed_n;
			errors_q <= errors_n;
		end
	end

	`APC_ASSERT_NOW(a_keys_bounded, clk, arst_n, 1'b1, keys_q <= KEYS_MAX, "key count beyond limit")
	`APC_ASSERT_NEXT(a_idle_holds, clk, arst_n, !fire, $stable(phase_q) && $stable(parsed_q), "state moved without a transaction")
	`APC_ASSERT_NEXT(a_verdict_drains, clk, arst_n, fire && verdict, phase_q == PH_DRAIN || phase_q == PH_SEARCH, "parser kept going after a verdict")
	`APC_ASSERT_NEXT(a_counters_grow, clk, arst_n, 1'b1, parsed_q >= $past(parsed_q) && errors_q >= $past(errors_q), "counter went down")

endmodule
